@@ rtl/sfme_pkg.sv @@
// ----------------------------------------------------------------------------
// sfme_pkg: shared types and helpers for the flow meter estimator
// Division lane word, step count and lane setup used by the divider chains.
// ----------------------------------------------------------------------------
package sfme_pkg;

	localparam int NUM_W     = 48;
	localparam int DIV_STEPS = 33;
	localparam int REM_W     = 33;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	// register indexes
	localparam logic [2:0] REG_STARTUP_PULSES = 3'd0;
	localparam logic [2:0] REG_STARTUP_VOLUME = 3'd1;
	localparam logic [2:0] REG_STABLE_PPL     = 3'd2;
	localparam logic [2:0] REG_STARTUP_TIME   = 3'd3;
	localparam logic [2:0] REG_STABLE_FLOW    = 3'd4;

	// one restoring division in flight
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
		logic [31:0]      d;
		logic [REM_W-1:0] q;
		logic             ovf;
	} div_lane_t;

	// set up a lane: the top numerator bits seed the remainder, and a
	// quotient of 2^33 or more is flagged as overflow up front
	function automatic div_lane_t lane_init(input logic [NUM_W-1:0] num,
			input logic [31:0] d);
		div_lane_t l;
		l.rem = {18'd0, num[NUM_W-1:DIV_STEPS]};
		l.ovf = {18'd0, num[NUM_W-1:DIV_STEPS]} >= {1'b0, d};
		l.num = {num[DIV_STEPS-1:0], 15'd0};
		l.d   = d;
		l.q   = '0;
		return l;
	endfunction

endpackage

@@ rtl/sfme_div_cell.sv @@
// ----------------------------------------------------------------------------
// sfme_div_cell: one restoring division step
// Takes one numerator bit, compare-subtracts the divisor, hands on the lane.
// ----------------------------------------------------------------------------
module sfme_div_cell import sfme_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  div_lane_t lane_i,
	output div_lane_t lane_o
);

	logic [REM_W-1:0] r2;
	logic             ge;

	// shift in next bit and trial subtract
	always_comb begin
		r2 = {lane_i.rem[REM_W-2:0], lane_i.num[NUM_W-1]};
		ge = r2 >= {1'b0, lane_i.d};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o.rem <= ge ? (r2 - {1'b0, lane_i.d}) : r2;
			lane_o.num <= {lane_i.num[NUM_W-2:0], 1'b0};
			lane_o.d   <= lane_i.d;
			lane_o.q   <= {lane_i.q[REM_W-2:0], ge};
			lane_o.ovf <= lane_i.ovf;
		end
	end

endmodule

@@ rtl/segmented_flow_meter_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// segmented_flow_meter_estimator_unit: two-segment flow meter conversions
// Pulses, fill time, volume for time and run pulses per liter per request.
// ----------------------------------------------------------------------------
// One request enters per cycle unless output back-pressure has filled the
// pipe. It runs through two chains of 33 one-bit divider cells, the first
// doing pulses, fill time and volume side by side, the second the pulses per
// liter that depends on the pulse count. Every stage moves on its own when
// the one after it is empty or moving, so the pipe keeps filling while the
// output word waits. The user writes registers through the config channel
// only while no request is in flight (not enforced); it is always ready.
module segmented_flow_meter_estimator_unit import sfme_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // target_ml[31:0], elapsed_ms[63:32]
	output logic         m_tvalid,
	input  logic         m_tready,
	// pulse_count[31:0], run_pulses_per_liter[63:32], fill_time_ms[95:64],
	// volume_for_time_ml[127:96], estimate_ok[128], settings_ok[129], zero pad
	output logic [135:0] m_tdata
);

	localparam int C1_BASE = 2;
	localparam int P_IDX   = C1_BASE + DIV_STEPS;
	localparam int M_IDX   = P_IDX + 1;
	localparam int C2_BASE = M_IDX + 1;
	localparam int O_IDX   = C2_BASE + DIV_STEPS;
	localparam int NSTG    = O_IDX + 1;

	typedef struct packed {
		logic [31:0] tgt;
		logic        pul_start;
		logic [15:0] pul_add;
		logic        pul_zero;
		logic [15:0] time_add;
		logic        time_zero;
		logic [15:0] vol_add;
		logic        vol_zero;
		logic        ok;
	} side1_t;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] fill;
		logic [31:0] vol;
		logic        zero;
		logic        ok;
	} side2_t;

	typedef struct packed {
		logic [31:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [31:0] d;
	} mul_op_t;

	// config registers
	logic [15:0] sp_q, sv_q, sppl_q, st_q, flow_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			sv_q   <= '0;
			sppl_q <= '0;
			st_q   <= '0;
			flow_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STARTUP_PULSES: sp_q   <= cfg_data;
				REG_STARTUP_VOLUME: sv_q   <= cfg_data;
				REG_STABLE_PPL:     sppl_q <= cfg_data;
				REG_STARTUP_TIME:   st_q   <= cfg_data;
				REG_STABLE_FLOW:    flow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid and ready chain
	logic [NSTG-1:0] v_q;
	logic [NSTG:0]   rdy;

	assign rdy[NSTG] = m_tready;
	genvar gk;
	generate
		for (gk = 0; gk < NSTG; gk++) begin : g_rdy
			assign rdy[gk] = !v_q[gk] || rdy[gk+1];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = v_q[O_IDX];

	// operand selection
	logic [31:0] tgt, ms;
	logic        ok, flow_only;
	mul_op_t     op [3];
	side1_t      side_n;

	assign tgt = s_tdata[31:0];
	assign ms  = s_tdata[63:32];

	always_comb begin
		ok        = (sp_q == 16'd0) == (sv_q == 16'd0);
		flow_only = (st_q == 16'd0) || (sv_q == 16'd0);
		side_n           = '0;
		side_n.tgt       = tgt;
		side_n.ok        = ok;
		side_n.pul_zero  = !ok || tgt == 32'd0 || sppl_q == 16'd0;
		side_n.time_zero = !ok || tgt == 32'd0 || flow_q == 16'd0;
		side_n.vol_zero  = !ok || ms == 32'd0 || flow_q == 16'd0;
		side_n.pul_start = sp_q != 16'd0 && sv_q != 16'd0 && tgt <= {16'd0, sv_q};
		// pulses
		if (side_n.pul_start) begin
			op[0] = '{a: tgt, b: sp_q, c: sv_q - 16'd1, d: {16'd0, sv_q}};
			side_n.pul_add = '0;
		end else begin
			op[0] = '{a: (tgt > {16'd0, sv_q}) ? tgt - {16'd0, sv_q} : 32'd0,
				b: sppl_q, c: 16'd999, d: 32'd1000};
			side_n.pul_add = sp_q;
		end
		// fill time
		if (flow_only) begin
			op[1] = '{a: tgt, b: 16'd60000, c: {1'b0, flow_q[15:1]},
				d: {16'd0, flow_q}};
		end else if (tgt <= {16'd0, sv_q}) begin
			op[1] = '{a: tgt, b: st_q, c: {1'b0, sv_q[15:1]}, d: {16'd0, sv_q}};
		end else begin
			op[1] = '{a: tgt - {16'd0, sv_q}, b: 16'd60000, c: {1'b0, flow_q[15:1]},
				d: {16'd0, flow_q}};
			side_n.time_add = st_q;
		end
		// volume for time
		if (flow_only) begin
			op[2] = '{a: ms, b: flow_q, c: 16'd30000, d: 32'd60000};
		end else if (ms <= {16'd0, st_q}) begin
			op[2] = '{a: ms, b: sv_q, c: {1'b0, st_q[15:1]}, d: {16'd0, st_q}};
		end else begin
			op[2] = '{a: ms - {16'd0, st_q}, b: flow_q, c: 16'd30000, d: 32'd60000};
			side_n.vol_add = sv_q;
		end
	end

	// s1: operands registered
	mul_op_t op_s1 [3];
	side1_t  side_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			op_s1   <= op;
			side_s1 <= side_n;
		end
	end

	// s2: multiply and seed the first divider chain
	div_lane_t ch1  [3][DIV_STEPS+1];
	side1_t    side1 [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			ch1[0][0] <= lane_init(NUM_W'(op_s1[0].a) * NUM_W'(op_s1[0].b)
				+ NUM_W'(op_s1[0].c), op_s1[0].d);
			ch1[1][0] <= lane_init(NUM_W'(op_s1[1].a) * NUM_W'(op_s1[1].b)
				+ NUM_W'(op_s1[1].c), op_s1[1].d);
			ch1[2][0] <= lane_init(NUM_W'(op_s1[2].a) * NUM_W'(op_s1[2].b)
				+ NUM_W'(op_s1[2].c), op_s1[2].d);
			side1[0] <= side_s1;
		end
	end

	genvar gl, gj;
	generate
		for (gj = 0; gj < DIV_STEPS; gj++) begin : g_c1
			for (gl = 0; gl < 3; gl++) begin : g_lane
				sfme_div_cell u_cell (
					.clk   (clk),
					.en    (rdy[C1_BASE+gj]),
					.lane_i(ch1[gl][gj]),
					.lane_o(ch1[gl][gj+1])
				);
			end
			always_ff @(posedge clk) begin
				if (rdy[C1_BASE+gj]) begin
					side1[gj+1] <= side1[gj];
				end
			end
		end
	endgenerate

	// saturating quotient plus offset
	function automatic logic [31:0] sat_add(input div_lane_t l, input logic [15:0] add);
		logic [32:0] s;
		s = {1'b0, l.q[31:0]} + 33'(add);
		return (l.ovf || l.q[32] || s[32]) ? SAT32 : s[31:0];
	endfunction

	// p: finish first chain
	side1_t      sd;
	logic [31:0] pc_p, fill_p, vol_p, tgt_p;
	logic        ok_p;

	assign sd = side1[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (rdy[P_IDX]) begin
			pc_p   <= sd.pul_zero  ? 32'd0 : sat_add(ch1[0][DIV_STEPS], sd.pul_add);
			fill_p <= sd.time_zero ? 32'd0 : sat_add(ch1[1][DIV_STEPS], sd.time_add);
			vol_p  <= sd.vol_zero  ? 32'd0 : sat_add(ch1[2][DIV_STEPS], sd.vol_add);
			tgt_p  <= sd.tgt;
			ok_p   <= sd.ok;
		end
	end

	// m: seed the pulses per liter chain
	div_lane_t ch2   [DIV_STEPS+1];
	side2_t    side2 [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (rdy[M_IDX]) begin
			ch2[0] <= lane_init(NUM_W'(pc_p) * NUM_W'(10'd1000) + NUM_W'(tgt_p[31:1]),
				tgt_p);
			side2[0] <= '{pc: pc_p, fill: fill_p, vol: vol_p,
				zero: pc_p == 32'd0 || tgt_p == 32'd0, ok: ok_p};
		end
	end

	generate
		for (gj = 0; gj < DIV_STEPS; gj++) begin : g_c2
			sfme_div_cell u_cell (
				.clk   (clk),
				.en    (rdy[C2_BASE+gj]),
				.lane_i(ch2[gj]),
				.lane_o(ch2[gj+1])
			);
			always_ff @(posedge clk) begin
				if (rdy[C2_BASE+gj]) begin
					side2[gj+1] <= side2[gj];
				end
			end
		end
	endgenerate

	// output word
	side2_t      se;
	logic [31:0] ppl;

	assign se  = side2[DIV_STEPS];
	assign ppl = se.zero ? 32'd0 : sat_add(ch2[DIV_STEPS], 16'd0);

	always_ff @(posedge clk) begin
		if (rdy[O_IDX]) begin
			m_tdata <= {6'd0, se.ok, (se.pc != 32'd0 && ppl != 32'd0),
				se.vol, se.fill, ppl, se.pc};
		end
	end

	// checks
	a_bad_settings_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[129] |-> m_tdata[127:0] == 128'd0)
		else $error("results not cleared for inconsistent startup pair");

	a_estimate_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[128] |-> m_tdata[31:0] != 32'd0 && m_tdata[63:32] != 32'd0)
		else $error("estimate flag set with zero pulse data");

	a_no_pulses_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[63:32] == 32'd0)
		else $error("pulses per liter nonzero with zero pulses");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[0] |-> s_tready)
		else $error("input stalled with empty first stage");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: flow meter estimator unit
// Drives random and directed requests through the stream port, writes the
// calibration registers between phases and checks every result word against
// a predictor of the two-segment conversion.
// ----------------------------------------------------------------------------
module testbench;
	import sfme_pkg::*;

	typedef struct packed {
		logic [31:0] pulses;
		logic [31:0] ppl;
		logic [31:0] fill;
		logic [31:0] vol;
		logic        est_ok;
		logic        set_ok;
	} estimate_t;

	// calibration copy
	logic [15:0] cal_sp, cal_sv, cal_ppl, cal_st, cal_flow;

	function automatic logic [63:0] clamp32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic estimate_t estimate(input logic [31:0] tgt, input logic [31:0] ms);
		estimate_t e;
		logic [63:0] t, m, sp, sv, pl, st, fl, pc, ppl, ft, vf, rest;
		logic ok;
		t = tgt; m = ms; sp = cal_sp; sv = cal_sv; pl = cal_ppl; st = cal_st; fl = cal_flow;
		ok = (sp == 0) == (sv == 0);
		// pulses for target
		if (!ok || t == 0 || pl == 0) pc = 0;
		else if (sp > 0 && sv > 0 && t <= sv) pc = clamp32((t * sp + sv - 1) / sv);
		else begin
			rest = (t > sv) ? t - sv : 0;
			pc = clamp32(sp + (rest * pl + 999) / 1000);
		end
		// run pulses per liter
		if (pc == 0 || t == 0) ppl = 0;
		else ppl = clamp32((pc * 1000 + t / 2) / t);
		// fill time
		if (!ok || t == 0 || fl == 0) ft = 0;
		else if (st == 0 || sv == 0) ft = clamp32((t * 60000 + fl / 2) / fl);
		else if (t <= sv) ft = clamp32((t * st + sv / 2) / sv);
		else ft = clamp32(st + ((t - sv) * 60000 + fl / 2) / fl);
		// volume for time
		if (!ok || m == 0 || fl == 0) vf = 0;
		else if (st == 0 || sv == 0) vf = clamp32((m * fl + 30000) / 60000);
		else if (m <= st) vf = clamp32((m * sv + st / 2) / st);
		else vf = clamp32(sv + ((m - st) * fl + 30000) / 60000);
		e.pulses = pc[31:0]; e.ppl = ppl[31:0]; e.fill = ft[31:0]; e.vol = vf[31:0];
		e.est_ok = (pc > 0 && ppl > 0); e.set_ok = ok;
		return e;
	endfunction

	int errors = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	class estimate_board;
		estimate_t pending[$];
		function void note(input logic [31:0] tgt, input logic [31:0] ms);
			pending.push_back(estimate(tgt, ms));
		endfunction
		task check(input logic [135:0] w);
			estimate_t e;
			if (pending.size() == 0) begin
				report("unexpected word", w[31:0], 0);
				return;
			end
			e = pending.pop_front();
			if (w[31:0] !== e.pulses) report("pulse_count", w[31:0], e.pulses);
			if (w[63:32] !== e.ppl) report("run_pulses_per_liter", w[63:32], e.ppl);
			if (w[95:64] !== e.fill) report("fill_time_ms", w[95:64], e.fill);
			if (w[127:96] !== e.vol) report("volume_for_time_ml", w[127:96], e.vol);
			if (w[128] !== e.est_ok) report("estimate_ok", w[128], e.est_ok);
			if (w[129] !== e.set_ok) report("settings_ok", w[129], e.set_ok);
			if (w[135:130] !== 6'd0) report("pad", w[135:130], 0);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;
	logic s_tvalid = 0, s_tready;
	logic [63:0] s_tdata = 0;
	logic m_tvalid, m_tready = 0;
	logic [135:0] m_tdata;

	segmented_flow_meter_estimator_unit DUT (.*);

	initial forever #5 clk = ~clk;

	estimate_board board = new();
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;
	int quiet = 0;
	localparam int QUIET_LIMIT = 20000;

	// receiver and result check
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check(m_tdata);
	end
	always @(negedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// register write, only once every request word has come back
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		while (board.pending.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_STARTUP_PULSES: cal_sp = val;
			REG_STARTUP_VOLUME: cal_sv = val;
			REG_STABLE_PPL:     cal_ppl = val;
			REG_STARTUP_TIME:   cal_st = val;
			REG_STABLE_FLOW:    cal_flow = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_cal(input logic [15:0] sp, sv, pl, st, fl);
		write_reg(REG_STARTUP_PULSES, sp);
		write_reg(REG_STARTUP_VOLUME, sv);
		write_reg(REG_STABLE_PPL, pl);
		write_reg(REG_STARTUP_TIME, st);
		write_reg(REG_STABLE_FLOW, fl);
	endtask

	// one request word, with random idle cycles ahead of it
	task automatic send(input logic [31:0] tgt, input logic [31:0] ms);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1; s_tdata <= {ms, tgt};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note(tgt, ms);
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	function automatic logic [31:0] rand_val(input logic [15:0] near);
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(0, 3);
			2: return near + $urandom_range(0, 2) - 1;
			3: return $urandom_range(0, 2 * near + 10);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 200000);
		endcase
	endfunction

	task automatic drain;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_cal;
		logic [15:0] v[5];
		for (int i = 0; i < 5; i++) begin
			case ($urandom_range(3))
				0: v[i] = 0;
				1: v[i] = 16'hFFFF;
				default: v[i] = $urandom;
			endcase
		end
		// mostly consistent startup pair
		if ($urandom_range(3) != 0 && ((v[0] == 0) != (v[1] == 0))) v[0] = v[1];
		set_cal(v[0], v[1], v[2], v[3], v[4]);
	endtask

	initial begin
		int phase_idle[4] = '{0, 49, 0, 28};
		int phase_stall[4] = '{0, 0, 49, 28};
		cal_sp = 0; cal_sv = 0; cal_ppl = 0; cal_st = 0; cal_flow = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: reset values, then a typical setting and extremes
		send(100, 1000);
		set_cal(120, 50, 450, 3000, 2000);
		send(0, 0); send(1, 1); send(50, 3000); send(49, 2999); send(51, 3001);
		send(32'hFFFF_FFFF, 32'hFFFF_FFFF); send(1000, 60000);
		write_reg(3'd7, 16'h1234);
		write_reg(3'd5, 16'hFFFF);
		send(1000, 60000);
		set_cal(0, 50, 450, 3000, 2000);        // inconsistent pair
		send(100, 100); send(32'hFFFF_FFFF, 5);
		set_cal(0, 0, 0, 0, 0);
		send(100, 100);
		set_cal(0, 0, 65535, 0, 65535);         // no startup timing
		send(32'hFFFF_FFFF, 32'hFFFF_FFFF); send(7, 7); send(1, 1);
		set_cal(65535, 65535, 65535, 65535, 1);
		send(65535, 65535); send(65536, 65536); send(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		set_cal(10, 10, 1000, 0, 1000);         // zero startup time
		send(5, 5); send(20, 20);
		drain();
		// random phases
		for (int p = 0; p < 8; p++) begin
			send_idle = phase_idle[p % 4];
			recv_stall = phase_stall[p % 4];
			random_cal();
			for (int i = 0; i < 175; i++) send(rand_val(cal_sv), rand_val(cal_st));
			drain();
		end
		// long receiver hold-off while requests keep coming
		send_idle = 0; recv_stall = 0;
		set_cal(300, 100, 500, 1500, 3000);
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 150; i++) send(rand_val(cal_sv), rand_val(cal_st));
		join
		drain();
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

@@ files.f @@
rtl/sfme_pkg.sv
rtl/sfme_div_cell.sv
rtl/segmented_flow_meter_estimator_unit.sv
tb/sv/testbench.sv
